// ----- rtl/core/sasc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the suffix automaton substring counter.
// Holds payload structs and fixed sizes; no dependencies.
`default_nettype none
package sasc_pkg;

  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 26;
  localparam int SYM_W        = 5;
  localparam int CNT_W        = 20;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] distinct_count;
    logic             overflow;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/core/sasc_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// No package dependencies.
`default_nettype none
module sasc_ram #(
  parameter int W = 11,
  parameter int D = 2048
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/suffix_automaton_distinct_substrings.sv -----
`timescale 1ns / 1ps
// Suffix automaton distinct-substring counter, top level.
// Uses sasc_pkg and three sasc_ram instances (transitions, links, lengths).
//
// Usage: drive in_data and raise start; the symbol is taken at the edge where
// start is high and busy is low. Exactly one result follows for each taken
// item, shown on out_data for one cycle with out_valid high; the receiver
// cannot hold it off. A symbol outside the alphabet, or one that meets the
// length bound or the state capacity, gives its result in the cycle after it is taken.
// A real extension first clears the new state's row of transitions, one write
// per cycle, then walks the suffix links, each step one read then one
// read-modify-write of the transition memory.
// A clone adds a row copy through the same memory, then a walk that redirects
// the transitions from the source to the clone, one read and one write per step.
// After reset, and after each item marked last, the root row is cleared with
// busy high; the result of a last item is shown as the clearing begins.
`default_nettype none
module suffix_automaton_distinct_substrings #(
  parameter int MAX_LEN  = sasc_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = sasc_pkg::ALPHABET_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire sasc_pkg::in_item_t  in_data,
  output logic                   out_valid,
  output sasc_pkg::out_item_t    out_data
);

  localparam int NSTATES = 2 * MAX_LEN;
  localparam int SW      = $clog2(NSTATES);
  localparam int TD      = NSTATES * ALPHABET;
  localparam int TW      = $clog2(TD);
  localparam int CW      = $clog2(ALPHABET) + 1;
  localparam int CNT_W   = sasc_pkg::CNT_W;
  localparam int SYM_W   = sasc_pkg::SYM_W;

  localparam logic [TW-1:0]    ALPHA_T  = TW'(ALPHABET);
  localparam logic [CW-1:0]    ALPHA_C  = CW'(ALPHABET);
  localparam logic [SYM_W-1:0] ALPHA_S  = SYM_W'(ALPHABET);
  localparam logic [SW:0]      MAXLEN_L = (SW+1)'(MAX_LEN);
  localparam logic [SW:0]      TOP_ST   = (SW+1)'(NSTATES - 1);
  localparam logic [SW-1:0]    ROOT     = SW'(1);

  typedef enum logic [3:0] {
    S_RST, S_IDLE, S_CLR, S_WRD, S_WCHK, S_QCHK, S_CLNK, S_CP, S_RRD, S_RCHK, S_FIN
  } state_t;

  state_t state_r;
  logic [SYM_W-1:0] sym_r;
  logic             fin_r;
  logic [SW-1:0]    p_r, cur_r, q_r, clone_r, lnk_r;
  logic [SW-1:0]    new_len_r, plen_r, lnklen_r;
  logic [SW-1:0]    total_r, last_r, last_len_r;
  logic [CW-1:0]    idx_r;
  logic [CNT_W-1:0] cnt_r;

  // memory ports
  logic          t_we;
  logic [TW-1:0] t_waddr, t_raddr;
  logic [SW-1:0] t_wdata, t_rdata;
  logic          l_we;
  logic [SW-1:0] l_waddr, l_wdata, l_raddr, l_rdata;
  logic          n_we;
  logic [SW-1:0] n_waddr, n_wdata, n_raddr, n_rdata;

  logic [TW-1:0]    pc_addr, cur_base, q_base, clone_base;
  logic             accept, sym_ok, ovf_hit;
  logic [CNT_W-1:0] cnt_sum;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign pc_addr  = TW'(p_r) * ALPHA_T + TW'(sym_r);
  assign cur_base = TW'(cur_r) * ALPHA_T;
  assign q_base   = TW'(q_r) * ALPHA_T;
  assign clone_base = TW'(clone_r) * ALPHA_T;
  assign sym_ok   = in_data.symbol < ALPHA_S;
  assign ovf_hit  = ({1'b0, last_len_r} >= MAXLEN_L) ||
                    ({1'b0, total_r} + (SW+1)'(2) > TOP_ST);
  assign cnt_sum  = cnt_r + CNT_W'(new_len_r - lnklen_r);

  always_comb begin
    t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = '0;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = '0;
    case (state_r)
      S_RST: begin
        t_we    = 1'b1;
        t_waddr = ALPHA_T + TW'(idx_r);
        if (idx_r == '0) begin
          l_we = 1'b1; l_waddr = ROOT;
          n_we = 1'b1; n_waddr = ROOT;
        end
      end
      S_CLR: begin
        t_we    = 1'b1;
        t_waddr = cur_base + TW'(idx_r);
        if (idx_r == '0) begin
          n_we = 1'b1; n_waddr = cur_r; n_wdata = new_len_r;
        end
      end
      S_WRD: begin
        t_raddr = pc_addr;
        l_raddr = p_r;
        n_raddr = p_r;
      end
      S_WCHK: begin
        if (t_rdata == '0) begin
          t_we = 1'b1; t_waddr = pc_addr; t_wdata = cur_r;
        end else begin
          l_raddr = t_rdata;
          n_raddr = t_rdata;
        end
      end
      S_QCHK: begin
        if (n_rdata != plen_r + SW'(1)) begin
          n_we = 1'b1; n_waddr = total_r + SW'(1); n_wdata = plen_r + SW'(1);
          l_we = 1'b1; l_waddr = total_r + SW'(1); l_wdata = l_rdata;
        end
      end
      S_CLNK: begin
        l_we = 1'b1; l_waddr = q_r; l_wdata = clone_r;
      end
      S_CP: begin
        if (idx_r < ALPHA_C) begin
          t_raddr = q_base + TW'(idx_r);
        end
        if (idx_r != '0) begin
          t_we    = 1'b1;
          t_waddr = clone_base + TW'(idx_r) - TW'(1);
          t_wdata = t_rdata;
        end
      end
      S_RRD: begin
        t_raddr = pc_addr;
        l_raddr = p_r;
      end
      S_RCHK: begin
        if (t_rdata == q_r) begin
          t_we = 1'b1; t_waddr = pc_addr; t_wdata = clone_r;
        end
      end
      S_FIN: begin
        l_we = 1'b1; l_waddr = cur_r; l_wdata = lnk_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_RST;
      idx_r      <= '0;
      total_r    <= ROOT;
      last_r     <= ROOT;
      last_len_r <= '0;
      cnt_r      <= '0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_RST: begin
          idx_r <= idx_r + CW'(1);
          if (idx_r == ALPHA_C - CW'(1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            sym_r <= in_data.symbol;
            fin_r <= in_data.last;
            if (!sym_ok || ovf_hit) begin
              out_valid               <= 1'b1;
              out_data.distinct_count <= cnt_r;
              out_data.overflow       <= sym_ok;
              if (in_data.last) begin
                total_r <= ROOT; last_r <= ROOT; last_len_r <= '0; cnt_r <= '0;
                idx_r   <= '0;
                state_r <= S_RST;
              end
            end else begin
              cur_r     <= total_r + SW'(1);
              total_r   <= total_r + SW'(1);
              p_r       <= last_r;
              new_len_r <= last_len_r + SW'(1);
              idx_r     <= '0;
              state_r   <= S_CLR;
            end
          end
        end
        S_CLR: begin
          idx_r <= idx_r + CW'(1);
          if (idx_r == ALPHA_C - CW'(1)) begin
            state_r <= S_WRD;
          end
        end
        S_WRD: begin
          if (p_r == '0) begin
            lnk_r    <= ROOT;
            lnklen_r <= '0;
            state_r  <= S_FIN;
          end else begin
            state_r <= S_WCHK;
          end
        end
        S_WCHK: begin
          if (t_rdata == '0) begin
            p_r     <= l_rdata;
            state_r <= S_WRD;
          end else begin
            q_r     <= t_rdata;
            plen_r  <= n_rdata;
            state_r <= S_QCHK;
          end
        end
        S_QCHK: begin
          if (n_rdata == plen_r + SW'(1)) begin
            lnk_r    <= q_r;
            lnklen_r <= n_rdata;
            state_r  <= S_FIN;
          end else begin
            clone_r  <= total_r + SW'(1);
            total_r  <= total_r + SW'(1);
            lnk_r    <= total_r + SW'(1);
            lnklen_r <= plen_r + SW'(1);
            state_r  <= S_CLNK;
          end
        end
        S_CLNK: begin
          idx_r   <= '0;
          state_r <= S_CP;
        end
        S_CP: begin
          idx_r <= idx_r + CW'(1);
          if (idx_r == ALPHA_C) begin
            state_r <= S_RRD;
          end
        end
        S_RRD: begin
          state_r <= (p_r == '0) ? S_FIN : S_RCHK;
        end
        S_RCHK: begin
          if (t_rdata == q_r) begin
            p_r     <= l_rdata;
            state_r <= S_RRD;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          out_valid               <= 1'b1;
          out_data.distinct_count <= cnt_sum;
          out_data.overflow       <= 1'b0;
          if (fin_r) begin
            total_r <= ROOT; last_r <= ROOT; last_len_r <= '0; cnt_r <= '0;
            idx_r   <= '0;
            state_r <= S_RST;
          end else begin
            cnt_r      <= cnt_sum;
            last_r     <= cur_r;
            last_len_r <= new_len_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_RST;
      endcase
    end
  end

  sasc_ram #(.W(SW), .D(TD)) u_trans (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  sasc_ram #(.W(SW), .D(NSTATES)) u_link (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  sasc_ram #(.W(SW), .D(NSTATES)) u_len (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  a_item_answered: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid || busy))
    else $error("accepted item neither answered nor in progress");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, total_r} <= TOP_ST)
    else $error("state count beyond capacity");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, last_len_r} <= MAXLEN_L)
    else $error("prefix length beyond bound");

  a_clone_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CP) |-> (clone_r != q_r))
    else $error("clone copies onto its own source");

  a_link_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (lnk_r != '0 && lnk_r != cur_r))
    else $error("bad suffix link for new state");

endmodule
`default_nettype wire

// ----- tb/sv/sasc_checker.sv -----
`timescale 1ns / 1ps
// Checker for the suffix automaton substring counter: predicts each result
// from accepted transfers and compares it. Depends on sasc_pkg.
module sasc_checker #(
  parameter int MAX_LEN  = sasc_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = sasc_pkg::ALPHABET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  sasc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  sasc_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);

  localparam int NST = 2 * MAX_LEN;

  int unsigned trans [NST*ALPHABET];
  int unsigned link [NST];
  int unsigned slen [NST];
  int unsigned tail_state, n_states, substr_total;
  sasc_pkg::out_item_t expected_q [$];

  function automatic void clear_automaton();
    foreach (trans[i]) trans[i] = 0;
    foreach (link[i]) begin
      link[i] = 0;
      slen[i] = 0;
    end
    tail_state = 1;
    n_states = 1;
    substr_total = 0;
  endfunction

  function automatic void add_letter(int unsigned c);
    int unsigned p, cur, q, cl;
    p = tail_state;
    n_states++;
    cur = n_states;
    tail_state = cur;
    slen[cur] = slen[p % NST] + 1;
    while (p != 0 && trans[(p % NST)*ALPHABET + c] == 0) begin
      trans[(p % NST)*ALPHABET + c] = cur;
      p = link[p % NST];
    end
    if (p == 0) begin
      link[cur] = 1;
    end else begin
      q = trans[(p % NST)*ALPHABET + c] % NST;
      if (slen[q] == slen[p % NST] + 1) begin
        link[cur] = q;
      end else begin
        n_states++;
        cl = n_states;
        for (int k = 0; k < ALPHABET; k++) trans[cl*ALPHABET + k] = trans[q*ALPHABET + k];
        link[cl] = link[q];
        slen[cl] = slen[p % NST] + 1;
        link[q] = cl;
        link[cur] = cl;
        while (p != 0 && trans[(p % NST)*ALPHABET + c] == q) begin
          trans[(p % NST)*ALPHABET + c] = cl;
          p = link[p % NST];
        end
      end
    end
    substr_total += slen[cur] - slen[link[cur] % NST];
  endfunction

  function automatic sasc_pkg::out_item_t predict_count(sasc_pkg::in_item_t it);
    sasc_pkg::out_item_t r;
    r.overflow = 1'b0;
    if (it.symbol < ALPHABET) begin
      if (slen[tail_state % NST] >= MAX_LEN || n_states + 2 > NST - 1) r.overflow = 1'b1;
      else add_letter(it.symbol);
    end
    r.distinct_count = substr_total[sasc_pkg::CNT_W-1:0];
    if (it.last) clear_automaton();
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    clear_automaton();
  end

  always @(posedge clk) begin
    sasc_pkg::out_item_t e;
    int errs;
    errs = 0;
    if (rst_n) begin
      // Compare first: a result never shares its edge with its own transfer.
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (e.distinct_count !== out_data.distinct_count) begin
            $display("%0t: distinct_count expected %0d actual %0d", $time,
                     e.distinct_count, out_data.distinct_count);
            errs++;
          end
          if (e.overflow !== out_data.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time,
                     e.overflow, out_data.overflow);
            errs++;
          end
        end
      end
      if (start && !busy) expected_q.push_back(predict_count(in_data));
      if (errs != 0) fail_count <= fail_count + errs;
      pending <= expected_q.size();
    end
  end
endmodule

// ----- tb/sv/suffix_automaton_distinct_substrings_tb.sv -----
`timescale 1ns / 1ps
// Testbench top: drives symbol strings into the substring counter and gives
// the verdict. Depends on sasc_pkg, the block and sasc_checker.
module suffix_automaton_distinct_substrings_tb;

  localparam int WATCHDOG = 20000;
  localparam int SYM_W    = sasc_pkg::SYM_W;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  sasc_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  sasc_pkg::out_item_t out_data;
  int        fail_count, pending;
  int        idle_cycles = 0;
  bit        timed_out = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  suffix_automaton_distinct_substrings i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  sasc_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Hold one transfer until accepted, after a random gap; start stays high
  // when the next transfer follows with no gap.
  task automatic send_symbol(logic [SYM_W-1:0] sym, logic fin);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{symbol: sym, last: fin};
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol(int span);
    if ($urandom_range(0, 19) == 0) return SYM_W'($urandom_range(26, 31));
    return SYM_W'($urandom_range(0, span - 1));
  endfunction

  initial begin
    int n, span;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, out-of-alphabet, clone-heavy repeats, last handling.
    send_symbol(5'd0, 1'b0);
    send_symbol(5'd25, 1'b0);
    send_symbol(5'd31, 1'b0);
    send_symbol(5'd0, 1'b0);
    send_symbol(5'd25, 1'b1);
    send_symbol(5'd26, 1'b1);
    send_symbol(5'd1, 1'b0);
    send_symbol(5'd1, 1'b0);
    send_symbol(5'd2, 1'b0);
    send_symbol(5'd1, 1'b0);
    send_symbol(5'd1, 1'b0);
    send_symbol(5'd2, 1'b1);
    // Drain fully before the random part.
    start <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(posedge clk);
    // Fill past the length bound so that overflow appears, also on the closing item marked last.
    for (int i = 0; i < 1030; i++)
      send_symbol(SYM_W'($urandom_range(0, ($urandom_range(0, 1) != 0) ? 1 : 25)), 1'b0);
    send_symbol(5'd3, 1'b1);
    // Random strings, mostly short, small alphabets for deep clone chains.
    n = 0;
    while (n < 60) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      span = ($urandom_range(0, 2) == 0) ? 26 : $urandom_range(2, 4);
      for (int k = 0; k < len; k++) begin
        send_symbol(pick_symbol(span), (k == len - 1) ? 1'b1 : 1'b0);
        n++;
      end
    end
    start <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
